### rtl/packet_five_tuple_extractor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the five-tuple extractor.
// Every macro takes the clock and the reset, so each use stands on its own.
// ----------------------------------------------------------------------------
`ifndef PACKET_FIVE_TUPLE_EXTRACTOR_ASSERT_SVH
`define PACKET_FIVE_TUPLE_EXTRACTOR_ASSERT_SVH

// The expression must never be true at a clock edge outside reset.
`define PFT_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Whenever the antecedent holds, the consequent holds at the same edge.
`define PFT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Whenever the antecedent holds, the consequent holds at the next edge.
`define PFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/pft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types and header constants of the five-tuple extractor.
// ----------------------------------------------------------------------------
package pft_pkg;

   localparam logic [7:0]  ETH_LEN     = 8'd14;
   localparam logic [7:0]  IPV4_END    = 8'd34;
   localparam logic [7:0]  TCP_LEN     = 8'd20;
   localparam logic [7:0]  UDP_LEN     = 8'd8;
   localparam logic [6:0]  POS_MAX     = 7'd127;
   localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
   localparam logic [7:0]  PROTO_TCP   = 8'd6;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        drop;
      logic [47:0] dst_mac;
      logic [47:0] src_mac;
      logic [15:0] ether_type;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [7:0]  l4_protocol;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/pft_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_capture
// Front end: takes one frame byte per word, captures the header fields and
// forms the result on the final byte.
// ----------------------------------------------------------------------------
module pft_capture import pft_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   input  queue_status_type queue_status,
   output logic             push_valid,
   output result_type       push_data
);

   logic [6:0]  pos_ff, pos_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [47:0] dst_mac_ff, dst_mac_in;
   logic [47:0] src_mac_ff, src_mac_in;
   logic [15:0] ether_type_ff, ether_type_in;
   logic [31:0] src_ip_ff, src_ip_in;
   logic [31:0] dst_ip_ff, dst_ip_in;
   logic [7:0]  protocol_ff, protocol_in;
   logic [15:0] src_port_ff, src_port_in;
   logic [15:0] dst_port_ff, dst_port_in;

   logic       accept;
   logic [7:0] pos8;
   logic [7:0] len;
   logic [3:0] ihl_cur;
   logic [7:0] l4_start;
   logic [7:0] need;
   logic       is_ipv4;
   logic       is_tcp;
   logic       is_udp;
   logic       drop;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign pos8      = {1'b0, pos_ff};
   assign len       = pos8 + 8'd1;

   always_comb begin
      ihl_cur       = (pos8 == ETH_LEN) ? req_data_byte[3:0] : ihl_ff;
      l4_start      = ETH_LEN + {2'b00, ihl_cur, 2'b00};
      dst_mac_in    = dst_mac_ff;
      src_mac_in    = src_mac_ff;
      ether_type_in = ether_type_ff;
      src_ip_in     = src_ip_ff;
      dst_ip_in     = dst_ip_ff;
      protocol_in   = protocol_ff;
      src_port_in   = src_port_ff;
      dst_port_in   = dst_port_ff;
      if (accept) begin
         if (pos8 < 8'd6) begin
            dst_mac_in = {dst_mac_ff[39:0], req_data_byte};
         end else if (pos8 < 8'd12) begin
            src_mac_in = {src_mac_ff[39:0], req_data_byte};
         end else if (pos8 < ETH_LEN) begin
            ether_type_in = {ether_type_ff[7:0], req_data_byte};
         end
         if (pos8 == 8'd23) begin
            protocol_in = req_data_byte;
         end
         if (pos8 >= 8'd26 && pos8 < 8'd30) begin
            src_ip_in = {src_ip_ff[23:0], req_data_byte};
         end
         if (pos8 >= 8'd30 && pos8 < IPV4_END) begin
            dst_ip_in = {dst_ip_ff[23:0], req_data_byte};
         end
         if (pos8 >= l4_start && pos8 < l4_start + 8'd2) begin
            src_port_in = {src_port_ff[7:0], req_data_byte};
         end
         if (pos8 >= l4_start + 8'd2 && pos8 < l4_start + 8'd4) begin
            dst_port_in = {dst_port_ff[7:0], req_data_byte};
         end
      end
   end

   always_comb begin
      pos_in = pos_ff;
      ihl_in = ihl_ff;
      if (accept) begin
         if (req_last_byte) begin
            pos_in = '0;
            ihl_in = '0;
         end else begin
            ihl_in = ihl_cur;
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 7'd1;
            end
         end
      end
   end

   always_comb begin
      is_ipv4 = ether_type_in == ETYPE_IPV4;
      is_tcp  = protocol_in == PROTO_TCP;
      is_udp  = protocol_in == PROTO_UDP;
      need    = l4_start + (is_tcp ? TCP_LEN : UDP_LEN);
      drop    = (len < ETH_LEN) ||
                (is_ipv4 && ((len < IPV4_END) || ((is_tcp || is_udp) && (len < need))));
      push_data = '0;
      push_data.drop = drop;
      if (!drop) begin
         push_data.dst_mac    = dst_mac_in;
         push_data.src_mac    = src_mac_in;
         push_data.ether_type = ether_type_in;
         if (is_ipv4) begin
            push_data.src_ip      = src_ip_in;
            push_data.dst_ip      = dst_ip_in;
            push_data.l4_protocol = protocol_in;
            if (is_tcp || is_udp) begin
               push_data.src_port = src_port_in;
               push_data.dst_port = dst_port_in;
            end
         end
      end
   end

   assign push_valid = accept && req_last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ihl_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         ihl_ff <= ihl_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_mac_ff    <= dst_mac_in;
      src_mac_ff    <= src_mac_in;
      ether_type_ff <= ether_type_in;
      src_ip_ff     <= src_ip_in;
      dst_ip_ff     <= dst_ip_in;
      protocol_ff   <= protocol_in;
      src_port_ff   <= src_port_in;
      dst_port_ff   <= dst_port_in;
   end

endmodule

### rtl/pft_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_queue
// Short result queue between the capture front end and the output stage.
// ----------------------------------------------------------------------------
module pft_queue import pft_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  result_type       push_data,
   input  logic             pop,
   output result_type       pop_data,
   output queue_status_type status
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   result_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push_valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/pft_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_emit
// Back end: moves results from the queue into the output register and
// holds each one until the receiver takes it.
// ----------------------------------------------------------------------------
module pft_emit import pft_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type queue_status,
   input  result_type       pop_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output result_type       rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign pop       = !queue_status.empty && (!valid_ff || rsp_ready);
   assign valid_in  = pop || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= pop_data;
      end
   end

endmodule

### rtl/packet_five_tuple_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_five_tuple_extractor
// Ethernet, IPv4 and TCP/UDP header parser that yields one five-tuple result
// per frame.
// ----------------------------------------------------------------------------
// The req_ channel carries a frame one byte per word, in wire order, with
// req_last_byte set on the final byte. The rsp_ channel gives one word per
// frame: the MAC addresses, EtherType, IPv4 addresses, protocol and L4 ports,
// or the drop flag with every other field zero when the frame is too short.
// A byte is taken every cycle while the result queue has room, so frames of
// any length, down to one byte, stream at one byte per cycle.
// The result of a frame enters the two-entry queue at the edge that accepts
// its final byte and moves from there into the output register, which
// drives rsp_, once that register is free.
// When the receiver stalls, the output register holds its word and the queue
// fills; with both full, req_ready falls until a result is taken.
// Reset clears the byte position, the queue and the output valid flag; the
// block then waits for the first byte of a new frame.
// ----------------------------------------------------------------------------
`include "packet_five_tuple_extractor_assert.svh"

module packet_five_tuple_extractor import pft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_drop,
   output logic [47:0] rsp_dst_mac,
   output logic [47:0] rsp_src_mac,
   output logic [15:0] rsp_ether_type,
   output logic [31:0] rsp_src_ip,
   output logic [31:0] rsp_dst_ip,
   output logic [7:0]  rsp_l4_protocol,
   output logic [15:0] rsp_src_port,
   output logic [15:0] rsp_dst_port
);

   queue_status_type queue_status;
   logic             push_valid;
   result_type       push_data;
   logic             pop;
   result_type       pop_data;
   result_type       rsp_data;

   pft_capture u_capture (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .queue_status  (queue_status),
      .push_valid    (push_valid),
      .push_data     (push_data)
   );

   pft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_data   (pop_data),
      .status     (queue_status)
   );

   pft_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop_data     (pop_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   assign rsp_drop        = rsp_data.drop;
   assign rsp_dst_mac     = rsp_data.dst_mac;
   assign rsp_src_mac     = rsp_data.src_mac;
   assign rsp_ether_type  = rsp_data.ether_type;
   assign rsp_src_ip      = rsp_data.src_ip;
   assign rsp_dst_ip      = rsp_data.dst_ip;
   assign rsp_l4_protocol = rsp_data.l4_protocol;
   assign rsp_src_port    = rsp_data.src_port;
   assign rsp_dst_port    = rsp_data.dst_port;

   `PFT_ASSERT_SAME(a_drop_clears_fields, clock, reset,
      rsp_valid && rsp_drop,
      rsp_dst_mac == '0 && rsp_src_mac == '0 && rsp_ether_type == '0 &&
      rsp_src_ip == '0 && rsp_dst_ip == '0 && rsp_l4_protocol == '0 &&
      rsp_src_port == '0 && rsp_dst_port == '0,
      "Dropped frame carries nonzero fields.")

   `PFT_ASSERT_SAME(a_non_ipv4_no_l3, clock, reset,
      rsp_valid && rsp_ether_type != ETYPE_IPV4,
      rsp_src_ip == '0 && rsp_dst_ip == '0 && rsp_l4_protocol == '0 &&
      rsp_src_port == '0 && rsp_dst_port == '0,
      "Non-IPv4 frame carries IPv4 or port fields.")

   `PFT_ASSERT_NEVER(a_no_push_when_full, clock, reset,
      push_valid && queue_status.full,
      "Result pushed into a full queue.")

   `PFT_ASSERT_NEXT(a_last_byte_queued, clock, reset,
      req_valid && req_ready && req_last_byte,
      !queue_status.empty,
      "Final byte accepted but no result queued.")

endmodule
